@@ sv/pmd_pkg.sv @@
// Shared types and constants for the direct polynomial multiplier.
`timescale 1ns / 1ps

package pmd_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = 2 * COEF_W;
    localparam int ACC_W       = 38;
    localparam int IDX_W       = 7;
    localparam int CNT_W       = 7;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic                     last_pair;
    } in_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] product_coeff;
        logic [IDX_W-1:0]        coeff_index;
        logic                    last_result;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic issue;
        logic clear;
    } mac_ctl_t;

    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] index;
        logic             last;
    } emit_t;

endpackage

@@ sv/pmd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pmd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/pmd_mac.sv @@
// Shared multiply-accumulate pipeline: product register, then accumulator.
`timescale 1ns / 1ps

module pmd_mac (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pmd_pkg::mac_ctl_t                   ctl,
    input  logic signed [pmd_pkg::COEF_W-1:0]   a_data,
    input  logic signed [pmd_pkg::COEF_W-1:0]   b_data,
    output logic                                busy,
    output logic signed [pmd_pkg::ACC_W-1:0]    acc
);

    import pmd_pkg::*;

    logic                     rd_vld_reg;
    logic                     prod_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    assign prod_next = a_data * b_data;

    always_comb begin
        acc_next = acc_reg;
        if (ctl.clear) begin
            acc_next = '0;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= ctl.issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign busy = rd_vld_reg | prod_vld_reg;
    assign acc  = acc_reg;

    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.clear |-> !busy)
        else $error("Accumulator cleared while terms are in flight.");

    a_issue_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.issue |=> ##1 prod_vld_reg)
        else $error("Issued term did not reach the product stage.");

endmodule

@@ sv/pmd_ctrl.sv @@
// Sequencer: stores operand pairs and steps the shared MAC over each coefficient.
`timescale 1ns / 1ps

module pmd_ctrl #(
    parameter int MAX_LEN = pmd_pkg::MAX_LEN_DEF,
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               last_pair,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [AW-1:0]      rd_addr_a,
    output logic [AW-1:0]      rd_addr_b,
    output pmd_pkg::mac_ctl_t  mac_ctl,
    input  logic               mac_busy,
    input  logic               out_free,
    output pmd_pkg::emit_t     emit
);

    import pmd_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] pair_count_reg, pair_count_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic             ends_reg, ends_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] hi_reg, hi_next;

    logic             accept;
    logic [CNT_W-1:0] j;
    logic [CNT_W-1:0] n_new;
    logic             ends_new;
    logic [IDX_W-1:0] b_idx;
    logic [IDX_W:0]   final_k;
    logic             is_final;
    logic             can_emit;
    logic             more;
    logic [CNT_W:0]   tail_lo;

    assign accept   = s_valid && s_ready;
    assign j        = (pair_count_reg >= CNT_W'(MAX_LEN)) ? '0 : pair_count_reg;
    assign n_new    = j + CNT_W'(1);
    assign ends_new = last_pair || (n_new >= CNT_W'(MAX_LEN));
    assign b_idx    = k_reg - IDX_W'(i_reg);
    assign final_k  = {n_reg, 1'b0} - (IDX_W+1)'(2);
    assign is_final = ends_reg && ({1'b0, k_reg} == final_k);
    assign can_emit = !mac_busy && out_free;
    assign more     = ends_reg && !is_final;
    assign tail_lo  = {1'b0, k_reg} + (CNT_W+1)'(2) - {1'b0, n_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (i_reg == hi_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (can_emit) begin
                    state_next = more ? ST_ISSUE : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pair_count_next = pair_count_reg;
        n_next          = n_reg;
        ends_next       = ends_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        hi_next         = hi_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pair_count_next = ends_new ? '0 : n_new;
                    n_next          = n_new;
                    ends_next       = ends_new;
                    k_next          = IDX_W'(j);
                    i_next          = '0;
                    hi_next         = j;
                end
            end
            ST_ISSUE: begin
                if (i_reg != hi_reg) begin
                    i_next = i_reg + CNT_W'(1);
                end
            end
            ST_FINISH: begin
                if (can_emit && more) begin
                    k_next  = k_reg + IDX_W'(1);
                    i_next  = tail_lo[CNT_W-1:0];
                    hi_next = n_reg - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        wr_en         = accept;
        wr_addr       = j[AW-1:0];
        rd_addr_a     = i_reg[AW-1:0];
        rd_addr_b     = b_idx[AW-1:0];
        mac_ctl.issue = (state_reg == ST_ISSUE);
        mac_ctl.clear = accept || ((state_reg == ST_FINISH) && can_emit && more);
        emit.load     = (state_reg == ST_FINISH) && can_emit;
        emit.index    = k_reg;
        emit.last     = is_final;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pair_count_reg <= '0;
        end else begin
            state_reg      <= state_next;
            pair_count_reg <= pair_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        ends_reg <= ends_next;
        k_reg    <= k_next;
        i_reg    <= i_next;
        hi_reg   <= hi_next;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pair_count_reg < CNT_W'(MAX_LEN))
        else $error("Pair count left the store range.");

    a_b_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ISSUE) |-> (b_idx < IDX_W'(n_reg)) && (i_reg < n_reg))
        else $error("Operand read outside the stored pairs.");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.load && emit.last |-> pair_count_reg == '0)
        else $error("Final coefficient emitted with pairs still counted.");

endmodule

@@ sv/polynomial_multiply_direct_unit.sv @@
// Top level of the direct polynomial multiplier.
`timescale 1ns / 1ps

// Usage:
// The s_ channel takes one beat per coefficient pair (coef_a, coef_b, last_pair).
// Pair j is stored and the block returns c_j on the m_ channel. On the beat with
// last_pair set, or on the beat that fills the store of MAX_LEN pairs, it also
// returns c_n .. c_(2n-2), and the final coefficient carries last_result.
// Every coefficient is summed by one multiply-accumulate, one product per cycle:
// its terms pass the address, read, multiply and accumulate stages before the
// sum reaches the output register. A beat that does not end the operands is done
// once c_j is loaded; the ending beat then goes on to the tail coefficients.
// s_ready is high only between items; one item is worked on at a time.
// When the receiver stalls, the finished coefficient waits in the output register
// and the sequencer holds; a new pair may still be accepted once the work is done.
// Reset clears the pair count and empties the output register; the operand
// stores are not cleared and need no clearing pass.
module polynomial_multiply_direct_unit #(
    parameter int MAX_LEN = pmd_pkg::MAX_LEN_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pmd_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output pmd_pkg::out_t m_data
);

    import pmd_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr_a;
    logic [AW-1:0]            rd_addr_b;
    logic [COEF_W-1:0]        a_data;
    logic [COEF_W-1:0]        b_data;
    mac_ctl_t                 mac_ctl;
    logic                     mac_busy;
    logic signed [ACC_W-1:0]  acc;
    emit_t                    emit;
    logic                     out_free;

    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;

    pmd_ram #(.WIDTH(COEF_W), .DEPTH(MAX_LEN)) u_store_a (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_data.coef_a),
        .rd_addr (rd_addr_a),
        .rd_data (a_data)
    );

    pmd_ram #(.WIDTH(COEF_W), .DEPTH(MAX_LEN)) u_store_b (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_data.coef_b),
        .rd_addr (rd_addr_b),
        .rd_data (b_data)
    );

    pmd_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .last_pair (s_data.last_pair),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .mac_ctl   (mac_ctl),
        .mac_busy  (mac_busy),
        .out_free  (out_free),
        .emit      (emit)
    );

    pmd_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .a_data  (a_data),
        .b_data  (b_data),
        .busy    (mac_busy),
        .acc     (acc)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit.load) begin
            m_valid_next              = 1'b1;
            m_data_next.product_coeff = acc;
            m_data_next.coeff_index   = emit.index;
            m_data_next.last_result   = emit.last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("Sequencer took no time after a beat was accepted.");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.load |-> !m_valid_reg || m_ready)
        else $error("Coefficient loaded over a pending result.");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the direct polynomial multiplier.
`timescale 1ns / 1ps

module testbench;
    import pmd_pkg::*;

    localparam int MAX_LEN = MAX_LEN_DEF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    logic signed [COEF_W-1:0] op_a_mem [MAX_LEN];
    logic signed [COEF_W-1:0] op_b_mem [MAX_LEN];
    int pairs_held = 0;
    out_t coeff_queue [$];
    int error_count = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    polynomial_multiply_direct_unit #(
        .MAX_LEN(MAX_LEN)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic signed [ACC_W-1:0] coeff_at(int k, int n);
        longint acc;
        int lo;
        int hi;
        int i;
        acc = 0;
        lo = (k >= n) ? k - n + 1 : 0;
        hi = (k < n) ? k : n - 1;
        for (i = lo; i <= hi; i++) begin
            acc += longint'(op_a_mem[i]) * longint'(op_b_mem[k - i]);
        end
        return acc[ACC_W-1:0];
    endfunction

    function automatic void push_coeff(int k, int n, logic fin);
        out_t want;
        want.product_coeff = coeff_at(k, n);
        want.coeff_index = k[IDX_W-1:0];
        want.last_result = fin;
        coeff_queue.push_back(want);
    endfunction

    function automatic void predict_pair(in_t beat);
        int j;
        int n;
        int k;
        logic ends;
        if (pairs_held >= MAX_LEN) begin
            pairs_held = 0;
        end
        j = pairs_held;
        op_a_mem[j] = beat.coef_a;
        op_b_mem[j] = beat.coef_b;
        n = j + 1;
        ends = beat.last_pair || (n >= MAX_LEN);
        push_coeff(j, n, ends && (n == 1));
        if (ends) begin
            for (k = n; k < 2 * n - 1; k++) begin
                push_coeff(k, n, k == 2 * n - 2);
            end
            pairs_held = 0;
        end else begin
            pairs_held = n;
        end
    endfunction

    // Results are checked before the accepted pair is predicted in the same cycle.
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (coeff_queue.size() == 0) begin
                $error("unexpected result beat: index %0d, value %0d",
                       m_data.coeff_index, m_data.product_coeff);
                error_count++;
            end else begin
                want = coeff_queue.pop_front();
                if (m_data.product_coeff !== want.product_coeff) begin
                    $error("product_coeff: expected %0d, actual %0d",
                           want.product_coeff, m_data.product_coeff);
                    error_count++;
                end
                if (m_data.coeff_index !== want.coeff_index) begin
                    $error("coeff_index: expected %0d, actual %0d",
                           want.coeff_index, m_data.coeff_index);
                    error_count++;
                end
                if (m_data.last_result !== want.last_result) begin
                    $error("last_result: expected %0d, actual %0d",
                           want.last_result, m_data.last_result);
                    error_count++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            predict_pair(s_data);
        end
    end

    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic set_idling(int send_pct, int recv_pct);
        @(posedge aclk);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
    endtask

    task automatic send_pair(logic signed [COEF_W-1:0] a, logic signed [COEF_W-1:0] b,
                             logic last);
        int n_gap;
        in_t beat;
        n_gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            n_gap++;
        end
        @(negedge aclk);
        if (n_gap > 0) begin
            s_valid <= 1'b0;
            repeat (n_gap) @(negedge aclk);
        end
        beat.coef_a = a;
        beat.coef_b = b;
        beat.last_pair = last;
        s_valid <= 1'b1;
        s_data <= beat;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (coeff_queue.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [COEF_W-1:0] rand_coef();
        case ($urandom_range(9))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return '0;
            3: return -16'sd1;
            default: return COEF_W'($urandom_range(65535));
        endcase
    endfunction

    task automatic send_random_operands(int len);
        int i;
        logic last;
        for (i = 0; i < len; i++) begin
            last = (i == len - 1);
            if (len == MAX_LEN && last) begin
                last = 1'($urandom_range(1));
            end
            send_pair(rand_coef(), rand_coef(), last);
        end
    endtask

    function automatic int rand_length();
        int r;
        r = $urandom_range(99);
        if (r < 75) begin
            return $urandom_range(8, 1);
        end else if (r < 97) begin
            return $urandom_range(32, 9);
        end else if ($urandom_range(1) == 1) begin
            return MAX_LEN;
        end
        return $urandom_range(MAX_LEN - 1, 33);
    endfunction

    task automatic apply_reset();
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    endtask

    task automatic test_length_one();
        send_pair(16'sd32767, 16'sd32767, 1'b1);
        send_pair(-16'sd32768, -16'sd32768, 1'b1);
        send_pair(-16'sd32768, 16'sd32767, 1'b1);
        send_pair('0, '0, 1'b1);
    endtask

    task automatic test_short_operands();
        send_pair(16'sd1, -16'sd1, 1'b0);
        send_pair(16'sd256, 16'sd256, 1'b0);
        send_pair(-16'sd32768, 16'sd32767, 1'b1);
        send_pair(16'sd32767, -16'sd32768, 1'b0);
        send_pair(-16'sd1, -16'sd1, 1'b1);
        send_pair(16'sh5555, 16'shAAAA, 1'b0);
        send_pair(16'shAAAA, 16'sh5555, 1'b0);
        send_pair(-16'sd1, 16'sd1, 1'b0);
        send_pair(16'sd32767, -16'sd32768, 1'b1);
    endtask

    // The first run fills the store without a last flag; the second ends exactly at the top.
    task automatic test_full_store();
        int i;
        for (i = 0; i < MAX_LEN; i++) begin
            send_pair(-16'sd32768, -16'sd32768, 1'b0);
        end
        for (i = 0; i < MAX_LEN; i++) begin
            send_pair(-16'sd32768, 16'sd32767, i == MAX_LEN - 1);
        end
    endtask

    task automatic test_output_hold();
        set_idling(0, 0);
        @(posedge aclk);
        hold_req = 400;
        send_random_operands(16);
        send_random_operands(5);
    endtask

    task automatic test_drain_pause();
        set_idling(31, 31);
        send_random_operands(6);
        wait_drained();
        send_random_operands(9);
        wait_drained();
        send_random_operands(3);
    endtask

    task automatic test_random_traffic();
        int send_pcts [4] = '{0, 56, 0, 31};
        int recv_pcts [4] = '{0, 0, 56, 31};
        int p;
        int target;
        for (p = 0; p < 4; p++) begin
            set_idling(send_pcts[p], recv_pcts[p]);
            target = items_sent + 33;
            while (items_sent < target) begin
                send_random_operands(rand_length());
            end
        end
    endtask

    initial begin
        apply_reset();
        test_length_one();
        test_short_operands();
        set_idling(31, 31);
        test_full_store();
        test_output_hold();
        test_drain_pause();
        test_random_traffic();
        wait_drained();
        repeat (200) @(posedge aclk);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
